// ===== design/olss_pkg.sv =====
// shared types and constants of the ordered list shift store
package olss_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_DROP   = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_FIND   = 3'd4,
        REQ_READ   = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic append;
        logic insert;
        logic erase;
    } t_cell_op;

endpackage

// ===== design/olss_ifs.sv =====
// request and result channel interfaces of the ordered list shift store
interface olss_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [5:0]        position;
    logic signed [31:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface olss_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [4:0]        found_index;
    logic signed [31:0] read_value;
    logic [5:0]        entry_count;

    modport source (output valid, status, found_index, read_value, entry_count, input ready);
    modport sink   (input valid, status, found_index, read_value, entry_count, output ready);
endinterface

// ===== design/olss_cell.sv =====
// one list cell: holds an entry, shifts with its neighbors, compares for find
module olss_cell #(
    parameter int IDX       = 0,
    parameter int XW        = 6,
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  olss_pkg::t_cell_op     i_op,
    input  logic [XW-1:0]          i_pos,
    input  logic [XW-1:0]          i_count,
    input  logic [WORD_BITS-1:0]   i_word,
    input  logic [WORD_BITS-1:0]   i_prev,
    input  logic [WORD_BITS-1:0]   i_next,
    output logic [WORD_BITS-1:0]   o_entry,
    output logic                   o_match
);
    import olss_pkg::*;

    localparam logic [XW-1:0] IDX_X  = XW'(IDX);
    localparam logic [XW-1:0] IDX_X1 = XW'(IDX + 1);

    logic [WORD_BITS-1:0] r_entry;
    logic [WORD_BITS-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_op.append && (IDX_X == i_count)) begin
            n_entry = i_word;
        end
        if (i_op.insert) begin
            if (IDX_X == i_pos) begin
                n_entry = i_word;
            end else if ((IDX_X > i_pos) && (IDX_X <= i_count)) begin
                n_entry = i_prev;
            end
        end
        if (i_op.erase && (IDX_X >= i_pos) && (IDX_X1 < i_count)) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_word) && (IDX_X < i_count);

endmodule

// ===== design/olss_resolve.sv =====
// result stage: resolves the find match vector and holds the result register
module olss_resolve #(
    parameter int CAPACITY = 32,
    parameter int CW       = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  olss_pkg::t_status     i_status,
    input  logic                  i_is_find,
    input  logic [CAPACITY-1:0]   i_match,
    input  logic signed [31:0]    i_read_value,
    input  logic [CW-1:0]         i_count,
    output logic                  o_free,
    olss_rsp_if.source            o_rsp
);
    import olss_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic                r_p_valid;
    t_status             r_p_status;
    logic                r_p_find;
    logic [CAPACITY-1:0] r_p_match;
    logic signed [31:0]  r_p_read;
    logic [CW-1:0]       r_p_count;

    logic                r_o_valid;
    t_status             r_o_status;
    logic [IW-1:0]       r_o_index;
    logic signed [31:0]  r_o_read;
    logic [CW-1:0]       r_o_count;

    logic                w_move;
    logic [IW-1:0]       w_index;
    t_status             w_status;

    assign w_move = r_p_valid && (!r_o_valid || o_rsp.ready);
    assign o_free = !r_p_valid || w_move;

    // lowest matching cell wins
    always_comb begin
        w_index = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_p_match[i]) begin
                w_index = IW'(i);
            end
        end
    end

    always_comb begin
        w_status = r_p_status;
        if (r_p_find) begin
            w_status = (|r_p_match) ? ST_DONE : ST_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= i_load || (r_p_valid && !w_move);
            r_o_valid <= w_move || (r_o_valid && !o_rsp.ready);
        end
        if (i_load) begin
            r_p_status <= i_status;
            r_p_find   <= i_is_find;
            r_p_match  <= i_match;
            r_p_read   <= i_read_value;
            r_p_count  <= i_count;
        end
        if (w_move) begin
            r_o_status <= w_status;
            r_o_index  <= (r_p_find && (|r_p_match)) ? w_index : '0;
            r_o_read   <= r_p_read;
            r_o_count  <= r_p_count;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.found_index = 5'(r_o_index);
    assign o_rsp.read_value  = r_o_read;
    assign o_rsp.entry_count = 6'(r_o_count);

`ifndef SYNTH
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("request loaded while result stage is busy");
    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_p_find && (|r_p_match)) |-> r_p_match[w_index])
        else $error("found index does not point at a match");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_rsp.ready) |=> (r_o_valid && $stable(r_o_count)))
        else $error("stalled result changed");
`endif

endmodule

// ===== design/ordered_list_shift_store.sv =====
// ordered list shift store: a row of cells that append, drop, insert, erase, find and read
// a result is registered twice, first in the pending register and then in the output register of olss_resolve
// throughput: one request per cycle while the result side is not stalled; the list updates in the accept cycle
// the find result is resolved over the registered match row of all cells
// reset clears the fill count and the result stages; entries stay undefined until written
// a stalled result holds the request side once its stage is also full
module ordered_list_shift_store #(
    parameter int CAPACITY  = olss_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = olss_pkg::WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olss_req_if.sink   i_req,
    olss_rsp_if.source o_rsp
);
    import olss_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    logic                 w_free;
    logic                 w_acc;
    logic [XW-1:0]        w_pos;
    logic [XW-1:0]        w_cnt;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_full;
    logic                 w_empty;
    t_status              w_status;
    logic                 w_is_find;
    logic                 w_do_read;
    t_cell_op             w_op_raw;
    t_cell_op             w_op;
    logic [WORD_BITS-1:0] w_entries [CAPACITY];
    logic [CAPACITY-1:0]  w_match;
    logic [WORD_BITS-1:0] w_sel;
    logic signed [31:0]   w_sel_ext;
    logic signed [31:0]   w_read;

    assign w_acc   = i_req.valid && w_free;
    assign w_pos   = XW'(i_req.position);
    assign w_cnt   = XW'(r_count);
    assign w_full  = (r_count == CAP_C);
    assign w_empty = (r_count == '0);

    generate
        if (WORD_BITS > 32) begin : g_wide
            assign w_word    = {{(WORD_BITS - 32){i_req.value[31]}}, i_req.value};
            assign w_sel_ext = w_sel[31:0];
        end else if (WORD_BITS == 32) begin : g_equal
            assign w_word    = i_req.value;
            assign w_sel_ext = w_sel;
        end else begin : g_narrow
            assign w_word    = i_req.value[WORD_BITS-1:0];
            assign w_sel_ext = {{(32 - WORD_BITS){w_sel[WORD_BITS-1]}}, w_sel};
        end
    endgenerate

    assign w_sel  = w_entries[IW'(w_pos)];
    assign w_read = w_do_read ? w_sel_ext : '0;

    always_comb begin
        w_status  = ST_DONE;
        w_is_find = 1'b0;
        w_do_read = 1'b0;
        w_op_raw  = '0;
        n_count   = r_count;
        unique case (t_req'(i_req.req_type))
            REQ_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op_raw.append = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_DROP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op_raw.insert = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_ERASE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op_raw.erase = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_FIND: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_is_find = 1'b1;
                end
            end
            REQ_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_read = 1'b1;
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    assign w_op = w_acc ? w_op_raw : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [WORD_BITS-1:0] w_prev;
            logic [WORD_BITS-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_entries[g - 1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_next = w_entries[g];
            end else begin : g_mid_next
                assign w_next = w_entries[g + 1];
            end
            olss_cell #(
                .IDX       (g),
                .XW        (XW),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_pos   (w_pos),
                .i_count (w_cnt),
                .i_word  (w_word),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_entry (w_entries[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    olss_resolve #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_resolve (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_acc),
        .i_status     (w_status),
        .i_is_find    (w_is_find),
        .i_match      (w_match),
        .i_read_value (w_read),
        .i_count      (n_count),
        .o_free       (w_free),
        .o_rsp        (o_rsp)
    );

    assign i_req.ready = w_free;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.req_type == REQ_APPEND) && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the list");
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_status != ST_DONE)) |=> $stable(r_count))
        else $error("rejected request changed the fill count");
`endif

endmodule

// ===== tb/sv/ordered_list_shift_store_tb.sv =====
// testbench of the ordered list shift store: directed table, random requests, scoreboard
`timescale 1ns / 1ps

module ordered_list_shift_store_tb;
    import olss_pkg::*;

    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 50;
    localparam int RANDOM_PER_PHASE = 272;

    typedef struct packed {
        t_status            status;
        logic [4:0]         found_index;
        logic signed [31:0] read_value;
        logic [5:0]         entry_count;
    } t_result;

    typedef struct packed {
        logic [2:0]         kind;
        logic [5:0]         pos;
        logic signed [31:0] val;
        logic               rand_val;
        int                 reps;
        logic               typed;
        t_result            exp;
    } t_drow;

    localparam t_result NO_EXP = '{ST_DONE, 5'd0, 32'sd0, 6'd0};
    localparam int DIRECTED_ROWS = 28;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic rsp_take = 1'b0;

    olss_req_if req_ch ();
    olss_rsp_if rsp_ch ();

    assign rsp_ch.ready = rsp_take;

    ordered_list_shift_store u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic signed [31:0] list_words [CAPACITY_DEF];
    int                 list_count = 0;
    bit                 list_growing = 1'b1;
    t_result            pending_results [$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 req_idle_pct = 25;
    int                 rsp_idle_pct = 50;

    t_drow directed_rows [DIRECTED_ROWS] = '{
        '{REQ_READ,   6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 6'd0}},
        '{REQ_FIND,   6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 6'd0}},
        '{REQ_DROP,   6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 6'd0}},
        '{REQ_ERASE,  6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 6'd0}},
        '{REQ_INSERT, 6'd1,  32'sd5,          1'b0, 1,  1'b1, '{ST_RANGE, 5'd0, 32'sd0, 6'd0}},
        '{REQ_INSERT, 6'd0,  32'sh8000_0000,  1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd1}},
        '{REQ_APPEND, 6'd0,  32'sh7fff_ffff,  1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_READ,   6'd0,  32'sd0,          1'b0, 1,  1'b1,
            '{ST_DONE, 5'd0, 32'sh8000_0000, 6'd2}},
        '{REQ_READ,   6'd2,  32'sd0,          1'b0, 1,  1'b1, '{ST_RANGE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_READ,   6'd63, 32'sd0,          1'b0, 1,  1'b1, '{ST_RANGE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_INSERT, 6'd1,  -32'sd1,         1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd3}},
        '{REQ_FIND,   6'd0,  32'sh7fff_ffff,  1'b0, 1,  1'b1, '{ST_DONE, 5'd2, 32'sd0, 6'd3}},
        '{REQ_FIND,   6'd0,  32'sd0,          1'b0, 1,  1'b1,
            '{ST_NOTFOUND, 5'd0, 32'sd0, 6'd3}},
        '{REQ_ERASE,  6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_READ,   6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd0, -32'sd1, 6'd2}},
        '{REQ_ERASE,  6'd2,  32'sd0,          1'b0, 1,  1'b1, '{ST_RANGE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_UNUSED_6, 6'd63, -32'sd1,       1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_UNUSED_7, 6'd0,  32'sd9,        1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd2}},
        '{REQ_INSERT, 6'd2,  32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd3}},
        '{REQ_APPEND, 6'd0,  32'sd0,          1'b1, 29, 1'b0, NO_EXP},
        '{REQ_APPEND, 6'd0,  32'sd5,          1'b0, 1,  1'b1, '{ST_FULL, 5'd0, 32'sd0, 6'd32}},
        '{REQ_INSERT, 6'd32, 32'sd1,          1'b0, 1,  1'b1, '{ST_FULL, 5'd0, 32'sd0, 6'd32}},
        '{REQ_INSERT, 6'd33, 32'sd1,          1'b0, 1,  1'b1, '{ST_RANGE, 5'd0, 32'sd0, 6'd32}},
        '{REQ_READ,   6'd31, 32'sd0,          1'b0, 1,  1'b0, NO_EXP},
        '{REQ_FIND,   6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd2, 32'sd0, 6'd32}},
        '{REQ_ERASE,  6'd31, 32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd31}},
        '{REQ_ERASE,  6'd0,  32'sd0,          1'b0, 1,  1'b1, '{ST_DONE, 5'd0, 32'sd0, 6'd30}},
        '{REQ_DROP,   6'd0,  32'sd0,          1'b0, 30, 1'b0, NO_EXP}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result apply_list_request(input logic [2:0] kind,
                                                   input logic [5:0] pos,
                                                   input logic signed [31:0] val);
        t_result res;
        int      at;
        int      i;
        res = NO_EXP;
        at = int'(pos);
        case (kind)
            REQ_APPEND: begin
                if (list_count >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_count] = val;
                    list_count++;
                end
            end
            REQ_DROP: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_count--;
                end
            end
            REQ_INSERT: begin
                if (at > list_count) begin
                    res.status = ST_RANGE;
                end else if (list_count >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_count; i > at; i--) list_words[i] = list_words[i - 1];
                    list_words[at] = val;
                    list_count++;
                end
            end
            REQ_ERASE: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (at >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = at; i + 1 < list_count; i++) list_words[i] = list_words[i + 1];
                    list_count--;
                end
            end
            REQ_FIND: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_NOTFOUND;
                    for (i = 0; i < list_count; i++) begin
                        if (res.status == ST_NOTFOUND && list_words[i] == val) begin
                            res.status = ST_DONE;
                            res.found_index = 5'(i);
                        end
                    end
                end
            end
            REQ_READ: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (at >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_words[at];
                end
            end
            default: begin
            end
        endcase
        res.entry_count = 6'(list_count);
        return res;
    endfunction

    function automatic logic signed [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            case ($urandom_range(0, 3))
                0: return 32'sd0;
                1: return -32'sd1;
                2: return 32'sh8000_0000;
                default: return 32'sh7fff_ffff;
            endcase
        end
        if (pick < 5) return 32'($urandom_range(0, 7));
        return $urandom;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_result();
        t_result exp;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending");
        end else begin
            exp = pending_results.pop_front();
            if (rsp_ch.status !== exp.status)
                report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, exp.status));
            if (rsp_ch.found_index !== exp.found_index)
                report_mismatch($sformatf("found_index %0d, want %0d",
                                          rsp_ch.found_index, exp.found_index));
            if (rsp_ch.read_value !== exp.read_value)
                report_mismatch($sformatf("read_value %0d, want %0d",
                                          rsp_ch.read_value, exp.read_value));
            if (rsp_ch.entry_count !== exp.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          rsp_ch.entry_count, exp.entry_count));
        end
    endtask

    task automatic send_request(input logic [2:0] kind, input logic [5:0] pos,
                                input logic signed [31:0] val, input logic typed,
                                input t_result typed_exp);
        t_result predicted;
        while ($urandom_range(0, 99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.position <= pos;
        req_ch.value    <= val;
        forever begin
            @(posedge i_clk);
            if (req_ch.ready === 1'b1) break;
        end
        predicted = apply_list_request(kind, pos, val);
        if (typed) predicted = typed_exp;
        pending_results = {pending_results, predicted};
    endtask

    task automatic run_random(input int count);
        int                 n;
        int                 pick;
        int                 t_append;
        int                 t_insert;
        int                 t_drop;
        int                 t_erase;
        logic [2:0]         kind;
        logic [5:0]         pos;
        logic signed [31:0] val;
        for (n = 0; n < count; n++) begin
            if (list_count == CAPACITY_DEF) list_growing = 1'b0;
            else if (list_count == 0) list_growing = 1'b1;
            t_append = list_growing ? 30 : 10;
            t_insert = t_append + (list_growing ? 25 : 8);
            t_drop   = t_insert + (list_growing ? 8 : 25);
            t_erase  = t_drop + (list_growing ? 10 : 30);
            pick = $urandom_range(0, 99);
            if (pick < t_append) kind = REQ_APPEND;
            else if (pick < t_insert) kind = REQ_INSERT;
            else if (pick < t_drop) kind = REQ_DROP;
            else if (pick < t_erase) kind = REQ_ERASE;
            else if (pick < t_erase + 12) kind = REQ_FIND;
            else if (pick < t_erase + 24) kind = REQ_READ;
            else kind = pick[0] ? REQ_UNUSED_7 : REQ_UNUSED_6;
            if ($urandom_range(0, 99) < 85) pos = 6'($urandom_range(0, list_count));
            else pos = 6'($urandom_range(0, 63));
            val = random_word();
            if (kind == REQ_FIND && list_count > 0 && $urandom_range(0, 9) < 6)
                val = list_words[$urandom_range(0, list_count - 1)];
            send_request(kind, pos, val, 1'b0, NO_EXP);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_take) begin
            check_result();
        end
        rsp_take <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        int k;
        logic signed [31:0] v;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_APPEND;
        req_ch.position <= 6'd0;
        req_ch.value    <= 32'sd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        req_idle_pct = 25;
        rsp_idle_pct = 50;
        for (r = 0; r < DIRECTED_ROWS; r++) begin
            for (k = 0; k < directed_rows[r].reps; k++) begin
                v = directed_rows[r].rand_val ? random_word() : directed_rows[r].val;
                send_request(directed_rows[r].kind, directed_rows[r].pos, v,
                             directed_rows[r].typed, directed_rows[r].exp);
            end
        end
        run_random(RANDOM_PER_PHASE);

        req_idle_pct = 50;
        rsp_idle_pct = 25;
        run_random(RANDOM_PER_PHASE);

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
